// ===== rtl/core/adsr_pkg.sv =====
package adsr_pkg;

    localparam int TIME_BITS_DEF = 24;
    localparam int GAIN_BITS_DEF = 16;
    localparam int LEN_RESET     = 48;

    typedef enum logic [1:0] {
        REG_ATTACK  = 2'd0,
        REG_DECAY   = 2'd1,
        REG_SUSTAIN = 2'd2,
        REG_RELEASE = 2'd3
    } t_reg;

    // sideband that travels with each word through the divider row
    typedef struct packed {
        logic valid;
        logic sub;
    } t_ctl;

endpackage

// ===== rtl/core/adsr_front.sv =====
module adsr_front
    import adsr_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int GAIN_BITS = GAIN_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic signed [TIME_BITS:0] i_elapsed_time,
    input  logic [TIME_BITS-1:0]    i_note_length,
    input  logic [TIME_BITS-1:0]    i_attack_length,
    input  logic [TIME_BITS-1:0]    i_decay_length,
    input  logic [GAIN_BITS-1:0]    i_sustain_level,
    input  logic [TIME_BITS-1:0]    i_release_length,
    output t_ctl                    o_ctl,
    output logic [TIME_BITS-1:0]    o_rem,
    output logic [GAIN_BITS-2:0]    o_low,
    output logic [TIME_BITS-1:0]    o_den,
    output logic [GAIN_BITS-1:0]    o_base
);

    localparam int TB = TIME_BITS;
    localparam int GB = GAIN_BITS;
    localparam int QB = GAIN_BITS - 1;
    localparam logic [GB-1:0] UNITY = {1'b1, {(GB-1){1'b0}}};

    // stage 1: captured word
    logic          r1_v, r1_neg;
    logic [TB-1:0] r1_e, r1_held;
    // stage 2: past attack?
    logic          r2_v, r2_neg, r2_lta;
    logic [TB-1:0] r2_e, r2_d1, r2_held;
    // stage 3: past decay?
    logic          r3_v, r3_neg, r3_lta, r3_ltd;
    logic [TB-1:0] r3_e, r3_d1, r3_d2, r3_held;
    // stage 4: past sustain?
    logic          r4_v, r4_neg, r4_lta, r4_ltd, r4_ltl;
    logic [TB-1:0] r4_e, r4_d1, r4_d3;
    // stage 5: phase operands
    logic          r5_v, r5_sub;
    logic [TB-1:0] r5_x, r5_den;
    logic [GB-1:0] r5_g, r5_base;
    // stage 6: product
    logic            r6_v, r6_sub;
    logic [TB+QB-1:0] r6_n;
    logic [TB-1:0]   r6_den;
    logic [GB-1:0]   r6_base;

    logic [TB:0]    n_d1, n_d2, n_d3, n_d4;
    logic [TB-1:0]  n_x, n_den;
    logic [GB-1:0]  n_g, n_base;
    logic           n_sub;
    logic [TB+GB-1:0] n_prod;

    always_comb begin
        n_d1 = {1'b0, r1_e} - {1'b0, i_attack_length};
        n_d2 = {1'b0, r2_d1} - {1'b0, i_decay_length};
        n_d3 = {1'b0, r3_d2} - {1'b0, r3_held};
        n_d4 = {1'b0, r4_d3} - {1'b0, i_release_length};
        n_prod = {{GB{1'b0}}, r5_x} * {{TB{1'b0}}, r5_g};
    end

    // pick the ramp: the divider computes x*g/den, the output adds or subtracts it from base
    always_comb begin
        n_x    = '0;
        n_g    = '0;
        n_den  = TB'(1);
        n_base = '0;
        n_sub  = 1'b0;
        priority if (r4_neg) begin
            n_base = '0;
        end else if (r4_lta) begin
            n_x   = r4_e;
            n_g   = UNITY;
            n_den = i_attack_length;
        end else if (r4_ltd) begin
            n_x    = r4_d1;
            n_g    = UNITY - i_sustain_level;
            n_den  = i_decay_length;
            n_base = UNITY;
            n_sub  = 1'b1;
        end else if (r4_ltl) begin
            n_base = i_sustain_level;
        end else if (n_d4[TB]) begin
            n_x    = r4_d3;
            n_g    = i_sustain_level;
            n_den  = i_release_length;
            n_base = i_sustain_level;
            n_sub  = 1'b1;
        end else begin
            n_base = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            r1_v <= i_accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end

        r1_neg  <= i_elapsed_time[TB];
        r1_e    <= i_elapsed_time[TB-1:0];
        r1_held <= i_note_length;

        r2_neg  <= r1_neg;
        r2_lta  <= n_d1[TB];
        r2_e    <= r1_e;
        r2_d1   <= n_d1[TB-1:0];
        r2_held <= r1_held;

        r3_neg  <= r2_neg;
        r3_lta  <= r2_lta;
        r3_ltd  <= n_d2[TB];
        r3_e    <= r2_e;
        r3_d1   <= r2_d1;
        r3_d2   <= n_d2[TB-1:0];
        r3_held <= r2_held;

        r4_neg <= r3_neg;
        r4_lta <= r3_lta;
        r4_ltd <= r3_ltd;
        r4_ltl <= n_d3[TB];
        r4_e   <= r3_e;
        r4_d1  <= r3_d1;
        r4_d3  <= n_d3[TB-1:0];

        r5_x    <= n_x;
        r5_g    <= n_g;
        r5_den  <= n_den;
        r5_base <= n_base;
        r5_sub  <= n_sub;

        r6_n    <= n_prod[TB+QB-1:0];
        r6_den  <= r5_den;
        r6_base <= r5_base;
        r6_sub  <= r5_sub;
    end

    assign o_ctl.valid = r6_v;
    assign o_ctl.sub   = r6_sub;
    assign o_rem       = r6_n[TB+QB-1:QB];
    assign o_low       = r6_n[QB-1:0];
    assign o_den       = r6_den;
    assign o_base      = r6_base;

endmodule

// ===== rtl/core/adsr_cell.sv =====
module adsr_cell
    import adsr_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int GAIN_BITS = GAIN_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctl                 i_ctl,
    input  logic [TIME_BITS-1:0] i_rem,
    input  logic [GAIN_BITS-2:0] i_low,
    input  logic [TIME_BITS-1:0] i_den,
    input  logic [GAIN_BITS-2:0] i_quo,
    input  logic [GAIN_BITS-1:0] i_base,
    output t_ctl                 o_ctl,
    output logic [TIME_BITS-1:0] o_rem,
    output logic [GAIN_BITS-2:0] o_low,
    output logic [TIME_BITS-1:0] o_den,
    output logic [GAIN_BITS-2:0] o_quo,
    output logic [GAIN_BITS-1:0] o_base
);

    localparam int TB = TIME_BITS;
    localparam int QB = GAIN_BITS - 1;

    logic [TB:0] n_trial, n_diff;
    logic        n_ge;

    // shift in the next dividend bit, subtract the divisor if it fits
    always_comb begin
        n_trial = {i_rem, i_low[QB-1]};
        n_diff  = n_trial - {1'b0, i_den};
        n_ge    = !n_diff[TB];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= i_ctl;
        end
        o_rem  <= n_ge ? n_diff[TB-1:0] : n_trial[TB-1:0];
        o_low  <= {i_low[QB-2:0], 1'b0};
        o_den  <= i_den;
        o_quo  <= {i_quo[QB-2:0], n_ge};
        o_base <= i_base;
    end

endmodule

// ===== rtl/core/adsr_envelope_gain.sv =====
// Linear ADSR gain: takes one word per clock (busy stays low) and drives its
// gain with an o_valid strobe, one strobe per word, in order. Six register
// stages go to the capture, the phase compares and the ramp multiply,
// GAIN_BITS-1 to the row of divider cells (one quotient bit per cell), one to
// the output register. The result strobe cannot be held off; capture it on the
// cycle it appears. Config writes are taken every cycle but must only come
// while no word is in flight.
module adsr_envelope_gain
    import adsr_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int GAIN_BITS = GAIN_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [TIME_BITS:0] i_elapsed_time,
    input  logic [TIME_BITS-1:0]      i_note_length,
    output logic                      o_valid,
    output logic [GAIN_BITS-1:0]      o_gain,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [((TIME_BITS > GAIN_BITS) ? TIME_BITS : GAIN_BITS)-1:0] i_cfg_data
);

    localparam int TB  = TIME_BITS;
    localparam int GB  = GAIN_BITS;
    localparam int QB  = GAIN_BITS - 1;
    localparam int LAT = QB + 7;
    localparam logic [GB-1:0] UNITY = {1'b1, {(GB-1){1'b0}}};

    logic [TB-1:0] r_attack, r_decay, r_release;
    logic [GB-1:0] r_sustain;
    logic [GB-1:0] n_sus_in;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign n_sus_in    = i_cfg_data[GB-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= TB'(LEN_RESET);
            r_decay   <= TB'(LEN_RESET);
            r_sustain <= UNITY;
            r_release <= TB'(LEN_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg'(i_cfg_index))
                REG_ATTACK:  r_attack  <= i_cfg_data[TB-1:0];
                REG_DECAY:   r_decay   <= i_cfg_data[TB-1:0];
                REG_SUSTAIN: r_sustain <= (n_sus_in > UNITY) ? UNITY : n_sus_in;
                REG_RELEASE: r_release <= i_cfg_data[TB-1:0];
            endcase
        end
    end

    t_ctl          w_ctl  [0:QB];
    logic [TB-1:0] w_rem  [0:QB];
    logic [QB-1:0] w_low  [0:QB];
    logic [TB-1:0] w_den  [0:QB];
    logic [QB-1:0] w_quo  [0:QB];
    logic [GB-1:0] w_base [0:QB];

    adsr_front #(
        .TIME_BITS(TIME_BITS),
        .GAIN_BITS(GAIN_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (start && !busy),
        .i_elapsed_time  (i_elapsed_time),
        .i_note_length   (i_note_length),
        .i_attack_length (r_attack),
        .i_decay_length  (r_decay),
        .i_sustain_level (r_sustain),
        .i_release_length(r_release),
        .o_ctl           (w_ctl[0]),
        .o_rem           (w_rem[0]),
        .o_low           (w_low[0]),
        .o_den           (w_den[0]),
        .o_base          (w_base[0])
    );

    assign w_quo[0] = '0;

    for (genvar k = 0; k < QB; k++) begin : g_cell
        adsr_cell #(
            .TIME_BITS(TIME_BITS),
            .GAIN_BITS(GAIN_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_ctl[k]),
            .i_rem  (w_rem[k]),
            .i_low  (w_low[k]),
            .i_den  (w_den[k]),
            .i_quo  (w_quo[k]),
            .i_base (w_base[k]),
            .o_ctl  (w_ctl[k+1]),
            .o_rem  (w_rem[k+1]),
            .o_low  (w_low[k+1]),
            .o_den  (w_den[k+1]),
            .o_quo  (w_quo[k+1]),
            .o_base (w_base[k+1])
        );
    end

    logic [GB-1:0] n_gain;
    logic          r_valid;
    logic [GB-1:0] r_gain;

    // apply the ramp step to the phase's starting level
    assign n_gain = w_ctl[QB].sub ? (w_base[QB] - {1'b0, w_quo[QB]})
                                  : (w_base[QB] + {1'b0, w_quo[QB]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_ctl[QB].valid;
        end
        r_gain <= n_gain;
    end

    assign o_valid = r_valid;
    assign o_gain  = r_gain;

`ifndef NO_ASSERTIONS
    a_sustain_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sustain <= UNITY)
        else $error("sustain level above unity");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[0].valid |-> (w_rem[0] < w_den[0]))
        else $error("divider entry remainder not below divisor");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_gain <= UNITY))
        else $error("gain above unity");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without a word accepted at the pipeline depth");
`endif

endmodule

// ===== test/adsr_envelope_gain_checker.sv =====
module adsr_envelope_gain_checker
    import adsr_pkg::*;
#(
    parameter int CFG_W = (TIME_BITS_DEF > GAIN_BITS_DEF) ? TIME_BITS_DEF : GAIN_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic signed [TIME_BITS_DEF:0] i_elapsed_time,
    input  logic [TIME_BITS_DEF-1:0]      i_note_length,
    input  logic                          i_valid,
    input  logic [GAIN_BITS_DEF-1:0]      i_gain,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_W = TIME_BITS_DEF;
    localparam int GAIN_W = GAIN_BITS_DEF;
    localparam longint unsigned UNITY = 64'd1 << (GAIN_W - 1);
    localparam logic [GAIN_W-1:0] SUS_MAX = UNITY[GAIN_W-1:0];

    typedef struct {
        logic signed [TIME_W:0] ticks;
        logic [TIME_W-1:0]      held;
        logic [GAIN_W-1:0]      gain;
    } t_gain_due;

    t_gain_due         gain_due_q[$];
    logic [TIME_W-1:0] atk_len;
    logic [TIME_W-1:0] dcy_len;
    logic [TIME_W-1:0] rel_len;
    logic [GAIN_W-1:0] sus_lvl;
    int                mismatches = 0;

    function automatic logic [GAIN_W-1:0] predict_gain(input logic signed [TIME_W:0] ticks,
                                                       input logic [TIME_W-1:0] held);
        longint unsigned t;
        longint unsigned s;
        longint unsigned lvl;
        logic [GAIN_W-1:0] g;
        s = 64'(sus_lvl);
        t = 64'(ticks[TIME_W-1:0]);
        if (ticks[TIME_W]) begin
            lvl = 0;
        end else if (t < atk_len) begin
            lvl = (t * UNITY) / atk_len;
        end else begin
            t -= atk_len;
            if (t < dcy_len) begin
                lvl = UNITY - ((UNITY - s) * t) / dcy_len;
            end else begin
                t -= dcy_len;
                if (t < held) begin
                    lvl = s;
                end else if (t - held < rel_len) begin
                    lvl = s - (s * (t - held)) / rel_len;
                end else begin
                    lvl = 0;
                end
            end
        end
        g = lvl[GAIN_W-1:0];
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_gain_due due;
        if (!i_rst_n) begin
            atk_len = TIME_W'(LEN_RESET);
            dcy_len = TIME_W'(LEN_RESET);
            rel_len = TIME_W'(LEN_RESET);
            sus_lvl = SUS_MAX;
            gain_due_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                unique case (t_reg'(i_cfg_index))
                    REG_ATTACK:  atk_len = i_cfg_data[TIME_W-1:0];
                    REG_DECAY:   dcy_len = i_cfg_data[TIME_W-1:0];
                    // clamp to unity, bits above the gain width are dropped first
                    REG_SUSTAIN: sus_lvl = (i_cfg_data[GAIN_W-1:0] > SUS_MAX) ?
                                           SUS_MAX : i_cfg_data[GAIN_W-1:0];
                    REG_RELEASE: rel_len = i_cfg_data[TIME_W-1:0];
                endcase
            end
            if (i_valid) begin
                if (gain_due_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: gain word %0d with no word outstanding", $realtime, i_gain);
                end else begin
                    due = gain_due_q.pop_front();
                    if (due.gain !== i_gain) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: gain mismatch elapsed %0d note %0d: expected %0d got %0d",
                                     $realtime, due.ticks, due.held, due.gain, i_gain);
                    end
                end
            end
            if (i_start && !i_busy) begin
                due.ticks = i_elapsed_time;
                due.held  = i_note_length;
                due.gain  = predict_gain(i_elapsed_time, i_note_length);
                gain_due_q.push_back(due);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= gain_due_q.size();
    end

endmodule

// ===== test/adsr_envelope_gain_tb.sv =====
module adsr_envelope_gain_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import adsr_pkg::*;

    localparam int TIME_W = TIME_BITS_DEF;
    localparam int GAIN_W = GAIN_BITS_DEF;
    localparam int CFG_W = (TIME_W > GAIN_W) ? TIME_W : GAIN_W;
    localparam longint TIME_MAX = (64'sd1 <<< TIME_W) - 1;
    localparam int UNITY = 1 << (GAIN_W - 1);
    localparam int TAIL = GAIN_W + 12;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic signed [TIME_W:0] i_elapsed_time;
    logic [TIME_W-1:0]      i_note_length;
    logic                   o_valid;
    logic [GAIN_W-1:0]      o_gain;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [1:0]             i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;

    int                fail_count;
    int                pending_words;
    int                idle_pct;
    int unsigned       cycle_cnt = 0;
    logic [TIME_W-1:0] attack_ticks;
    logic [TIME_W-1:0] decay_ticks;
    logic [TIME_W-1:0] release_ticks;

    adsr_envelope_gain u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_elapsed_time (i_elapsed_time),
        .i_note_length  (i_note_length),
        .o_valid        (o_valid),
        .o_gain         (o_gain),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    adsr_envelope_gain_checker #(.CFG_W(CFG_W)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_elapsed_time (i_elapsed_time),
        .i_note_length  (i_note_length),
        .i_valid        (o_valid),
        .i_gain         (o_gain),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_word(input longint ticks, input logic [TIME_W-1:0] held);
        logic signed [TIME_W:0] word_ticks;
        word_ticks = (TIME_W+1)'((ticks > TIME_MAX) ? TIME_MAX : ticks);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_elapsed_time <= word_ticks;
        i_note_length  <= held;
        do @(posedge i_clk); while (busy);
    endtask

    // drop start and hold until every outstanding gain has come back
    task automatic drain_words();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
    endtask

    // leaves valid high; the caller drops it after the last word
    task automatic write_reg(input t_reg idx, input logic [CFG_W-1:0] data);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_config(input logic [TIME_W-1:0] atk, input logic [TIME_W-1:0] dcy,
                              input logic [CFG_W-1:0] sus, input logic [TIME_W-1:0] rel);
        write_reg(REG_ATTACK, atk);
        write_reg(REG_DECAY, dcy);
        write_reg(REG_SUSTAIN, sus);
        write_reg(REG_RELEASE, rel);
        i_cfg_valid   <= 1'b0;
        attack_ticks  = atk;
        decay_ticks   = dcy;
        release_ticks = rel;
    endtask

    // walk each phase edge of one note
    task automatic edge_words();
        logic [TIME_W-1:0] held;
        longint            mark;
        held = TIME_W'($urandom_range(0, 20));
        mark = 0;
        for (int k = 0; k < 5; k++) begin
            send_word(mark - 1, held);
            send_word(mark, held);
            case (k)
                0: mark += attack_ticks;
                1: mark += decay_ticks;
                2: mark += held;
                default: mark += release_ticks;
            endcase
        end
    endtask

    task automatic random_word();
        logic [TIME_W-1:0]      held;
        logic signed [TIME_W:0] raw;
        longint                 ticks;
        longint                 span;
        longint                 mark;
        int unsigned            kind;
        kind = $urandom_range(0, 3);
        held = (kind == 0) ? '0 : (kind == 1) ? TIME_W'($urandom) :
                                                TIME_W'($urandom_range(0, 300));
        span = longint'(attack_ticks) + decay_ticks + held + release_ticks;
        raw  = (TIME_W+1)'($urandom);
        case ($urandom_range(0, 9))
            0: ticks = raw;
            1: begin
                raw[TIME_W] = 1'b1;
                ticks = raw;
            end
            2, 3, 4: begin
                case ($urandom_range(0, 4))
                    0: mark = 0;
                    1: mark = attack_ticks;
                    2: mark = longint'(attack_ticks) + decay_ticks;
                    3: mark = longint'(attack_ticks) + decay_ticks + held;
                    default: mark = span;
                endcase
                ticks = mark + longint'($urandom_range(0, 4)) - 2;
            end
            default: ticks = $urandom_range(0, (span + 4 > TIME_MAX) ? TIME_MAX : span + 4);
        endcase
        send_word(ticks, held);
    endtask

    task automatic run_phase(input logic [TIME_W-1:0] atk, input logic [TIME_W-1:0] dcy,
                             input logic [CFG_W-1:0] sus, input logic [TIME_W-1:0] rel,
                             input int count, input int pct, input bit mid_drain);
        drain_words();
        set_config(atk, dcy, sus, rel);
        edge_words();
        idle_pct = pct;
        for (int n = 0; n < count; n++) begin
            if (mid_drain && n == count / 2)
                drain_words();
            random_word();
        end
        idle_pct = 19;
    endtask

    function automatic logic [TIME_W-1:0] pick_len();
        int unsigned roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return TIME_W'($urandom);
        return TIME_W'($urandom_range(1, 400));
    endfunction

    initial begin
        logic [CFG_W-1:0] sus_word;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_elapsed_time <= '0;
        i_note_length  <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= REG_ATTACK;
        i_cfg_data     <= '0;
        idle_pct       = 19;
        attack_ticks   = TIME_W'(LEN_RESET);
        decay_ticks    = TIME_W'(LEN_RESET);
        release_ticks  = TIME_W'(LEN_RESET);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset lengths: 48 each, sustain at unity
        send_word(-TIME_MAX - 1, TIME_W'(TIME_MAX));
        send_word(-1, 0);
        send_word(0, 0);
        send_word(1, 0);
        send_word(24, 5);
        send_word(47, 0);
        send_word(48, 0);
        send_word(95, 0);
        send_word(96, 0);
        send_word(143, 0);
        send_word(144, 0);
        send_word(195, 100);
        send_word(196, 100);
        send_word(TIME_MAX, TIME_W'(TIME_MAX));
        send_word(TIME_MAX, 0);
        edge_words();
        for (int n = 0; n < 90; n++)
            random_word();

        // zero-length phases are skipped
        run_phase(0, 0, 16'h4000, 0, 90, 19, 1'b0);
        // longest ramps, sustain write that saturates
        run_phase(TIME_W'(TIME_MAX), TIME_W'(TIME_MAX), {CFG_W{1'b1}}, TIME_W'(TIME_MAX),
                  90, 19, 1'b0);
        run_phase(1, 1, 0, 1, 90, 19, 1'b0);
        run_phase(5, 7, UNITY + 1, 3, 90, 19, 1'b0);
        // bits above the gain width are dropped before the clamp
        run_phase(200, 0, 1 << GAIN_W, 1000, 90, 19, 1'b0);
        run_phase(30, 60, UNITY, 90, 90, 19, 1'b0);

        for (int k = 0; k < 8; k++) begin
            sus_word = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom) :
                                                    CFG_W'($urandom_range(0, UNITY));
            run_phase(pick_len(), pick_len(), sus_word, pick_len(), 70,
                      (k == 2) ? 0 : 19, k == 4);
        end

        drain_words();
        repeat (TAIL) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/adsr_pkg.sv
rtl/core/adsr_front.sv
rtl/core/adsr_cell.sv
rtl/core/adsr_envelope_gain.sv
test/adsr_envelope_gain_checker.sv
test/adsr_envelope_gain_tb.sv
